// ----- hw/rtl/assert_macros.svh -----
// assertion helpers, sampled on clk and held off while rst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define AST_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
`define AST_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`define AST_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define AST_ALWAYS(lbl, cond, msg)
`define AST_IMP(lbl, ante, cons, msg)
`define AST_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ----- hw/rtl/ibfq_pkg.sv -----
`timescale 1ns / 1ps

package ibfq_pkg;

    localparam int ENTRIES_DEFAULT = 1024;

    localparam int OP_W     = 3;
    localparam int INDEX_W  = 10;
    localparam int COUNT_W  = 11;
    localparam int STATUS_W = 3;

    // opcodes
    localparam logic [OP_W-1:0] OP_RESET   = 3'd0;
    localparam logic [OP_W-1:0] OP_MARK    = 3'd1;
    localparam logic [OP_W-1:0] OP_RELEASE = 3'd2;
    localparam logic [OP_W-1:0] OP_QUERY   = 3'd3;
    localparam logic [OP_W-1:0] OP_TAKE    = 3'd4;
    localparam logic [OP_W-1:0] OP_REBUILD = 3'd5;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
    localparam logic [STATUS_W-1:0] ST_IN_USE     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_IN_USE = 3'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY      = 3'd3;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW   = 3'd4;

    // bitmap read address select
    localparam logic [1:0] RD_INPUT = 2'd0;
    localparam logic [1:0] RD_LATCH = 2'd1;
    localparam logic [1:0] RD_SWEEP = 2'd2;

    typedef struct packed {
        logic       accept;      // latch request, clear overflow flag
        logic [1:0] rd_sel;
        logic       sweep_clr;
        logic       sweep_step;
        logic       clear_wr;    // write zero at sweep address
        logic       count_clr;
        logic       scan_issue;  // rebuild scan read
        logic       exec;        // single-entry operation completes
        logic       finish;      // sweep operation or no-op completes
    } cmd_t;

    typedef struct packed {
        logic out_free;
        logic sweep_last;
    } sts_t;

endpackage

// ----- hw/rtl/ibfq_ctrl.sv -----
`timescale 1ns / 1ps

module ibfq_ctrl
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  logic [ibfq_pkg::OP_W-1:0]   in_opcode,
    output logic                        in_ready,
    input  ibfq_pkg::sts_t              sts,
    output ibfq_pkg::cmd_t              cmd
);

    localparam logic [2:0] S_INIT     = 3'd0;
    localparam logic [2:0] S_IDLE     = 3'd1;
    localparam logic [2:0] S_EXEC     = 3'd2;
    localparam logic [2:0] S_CLEAR    = 3'd3;
    localparam logic [2:0] S_SCAN     = 3'd4;
    localparam logic [2:0] S_SCAN_END = 3'd5;
    localparam logic [2:0] S_FINISH   = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        cmd        = '0;
        cmd.rd_sel = ibfq_pkg::RD_LATCH;
        case (state_reg)
            S_INIT:
            begin
                // bitmap clearing pass after reset
                cmd.rd_sel     = ibfq_pkg::RD_SWEEP;
                cmd.clear_wr   = 1'b1;
                cmd.sweep_step = 1'b1;
                if (sts.sweep_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                in_ready   = 1'b1;
                cmd.rd_sel = ibfq_pkg::RD_INPUT;
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    case (in_opcode)
                        ibfq_pkg::OP_RESET:
                        begin
                            cmd.sweep_clr = 1'b1;
                            cmd.count_clr = 1'b1;
                            state_next    = S_CLEAR;
                        end
                        ibfq_pkg::OP_MARK,
                        ibfq_pkg::OP_RELEASE,
                        ibfq_pkg::OP_QUERY,
                        ibfq_pkg::OP_TAKE:
                        begin
                            state_next = S_EXEC;
                        end
                        ibfq_pkg::OP_REBUILD:
                        begin
                            cmd.sweep_clr = 1'b1;
                            state_next    = S_SCAN;
                        end
                        default:
                        begin
                            state_next = S_FINISH;
                        end
                    endcase
                end
            end
            S_EXEC:
            begin
                if (sts.out_free)
                begin
                    cmd.exec   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_CLEAR:
            begin
                cmd.rd_sel     = ibfq_pkg::RD_SWEEP;
                cmd.clear_wr   = 1'b1;
                cmd.sweep_step = 1'b1;
                if (sts.sweep_last)
                begin
                    state_next = S_FINISH;
                end
            end
            S_SCAN:
            begin
                cmd.rd_sel     = ibfq_pkg::RD_SWEEP;
                cmd.scan_issue = 1'b1;
                cmd.sweep_step = 1'b1;
                if (sts.sweep_last)
                begin
                    state_next = S_SCAN_END;
                end
            end
            S_SCAN_END:
            begin
                // last scanned entry is pushed here
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (sts.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ----- hw/rtl/ibfq_datapath.sv -----
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ibfq_datapath
#(
    parameter int ENTRIES = ibfq_pkg::ENTRIES_DEFAULT
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic [ibfq_pkg::OP_W-1:0]       in_opcode,
    input  logic [ibfq_pkg::INDEX_W-1:0]    in_index,
    input  ibfq_pkg::cmd_t                  cmd,
    output ibfq_pkg::sts_t                  sts,
    input  logic                            out_ready,
    output logic                            out_valid,
    output logic                            out_entry_in_use,
    output logic [ibfq_pkg::INDEX_W-1:0]    out_free_index,
    output logic [ibfq_pkg::COUNT_W-1:0]    out_used_count,
    output logic [ibfq_pkg::STATUS_W-1:0]   out_status
);

    localparam int AW = $clog2(ENTRIES);
    localparam int CW = $clog2(ENTRIES + 1);
    localparam int XW = 17;

    // storage
    logic          bm_mem [ENTRIES];
    logic [AW-1:0] ff_mem [ENTRIES];

    logic [ibfq_pkg::OP_W-1:0]    op_reg;
    logic [ibfq_pkg::INDEX_W-1:0] idx_reg;
    logic [AW-1:0] sweep_reg, sweep_next;
    logic [CW-1:0] used_reg, used_next;
    logic [AW-1:0] head_reg, head_next;
    logic [AW-1:0] tail_reg, tail_next;
    logic [CW-1:0] fill_reg, fill_next;
    logic          ovf_reg, ovf_next;
    logic          scan_pend_reg;
    logic [AW-1:0] scan_idx_reg;
    logic          bm_rdata_reg;
    logic [AW-1:0] ff_rdata_reg;
    logic          out_valid_reg, out_valid_next;
    logic          out_bit_reg, out_bit_next;
    logic [ibfq_pkg::INDEX_W-1:0]  out_fidx_reg, out_fidx_next;
    logic [ibfq_pkg::COUNT_W-1:0]  out_used_reg, out_used_next;
    logic [ibfq_pkg::STATUS_W-1:0] out_status_reg, out_status_next;

    logic [XW-1:0] in_wide, idx_wide, used_wide, fidx_wide;
    logic          idx_ok;
    logic [AW-1:0] idx_addr, rd_addr;
    logic          fifo_full, fifo_empty, sweep_last;
    logic          bm_we, bm_wd;
    logic [AW-1:0] bm_wa;
    logic          push, pop, ovf_set, used_inc, used_dec;
    logic [AW-1:0] push_data;
    logic          res_bit;
    logic [ibfq_pkg::STATUS_W-1:0] res_status;
    logic          res_load;

    assign in_wide    = XW'(in_index);
    assign idx_wide   = XW'(idx_reg);
    assign idx_ok     = idx_wide < XW'(ENTRIES);
    assign idx_addr   = idx_wide[AW-1:0];
    assign fifo_full  = fill_reg == CW'(ENTRIES);
    assign fifo_empty = fill_reg == '0;
    assign sweep_last = sweep_reg == AW'(ENTRIES - 1);

    assign sts = '{out_free: (!out_valid_reg || out_ready), sweep_last: sweep_last};

    always_comb
    begin
        case (cmd.rd_sel)
            ibfq_pkg::RD_INPUT: rd_addr = in_wide[AW-1:0];
            ibfq_pkg::RD_SWEEP: rd_addr = sweep_reg;
            default:            rd_addr = idx_addr;
        endcase
    end

    // operation decode
    always_comb
    begin
        bm_we      = 1'b0;
        bm_wa      = idx_addr;
        bm_wd      = 1'b0;
        push       = 1'b0;
        push_data  = idx_addr;
        pop        = 1'b0;
        ovf_set    = 1'b0;
        used_inc   = 1'b0;
        used_dec   = 1'b0;
        res_bit    = 1'b0;
        res_status = ibfq_pkg::ST_OK;

        if (cmd.clear_wr)
        begin
            bm_we = 1'b1;
            bm_wa = sweep_reg;
        end

        // rebuild: push each free entry read in the previous cycle
        if (scan_pend_reg && !bm_rdata_reg)
        begin
            push_data = scan_idx_reg;
            if (fifo_full)
            begin
                ovf_set = 1'b1;
            end
            else
            begin
                push = 1'b1;
            end
        end

        if (cmd.exec)
        begin
            case (op_reg)
                ibfq_pkg::OP_MARK:
                begin
                    if (!idx_ok)
                    begin
                        res_status = ibfq_pkg::ST_NOT_IN_USE;
                    end
                    else if (bm_rdata_reg)
                    begin
                        res_status = ibfq_pkg::ST_IN_USE;
                        res_bit    = 1'b1;
                    end
                    else
                    begin
                        bm_we    = 1'b1;
                        bm_wd    = 1'b1;
                        used_inc = 1'b1;
                        res_bit  = 1'b1;
                    end
                end
                ibfq_pkg::OP_RELEASE:
                begin
                    if (!idx_ok || !bm_rdata_reg)
                    begin
                        res_status = ibfq_pkg::ST_NOT_IN_USE;
                    end
                    else
                    begin
                        bm_we    = 1'b1;
                        used_dec = used_reg != '0;
                        if (fifo_full)
                        begin
                            res_status = ibfq_pkg::ST_OVERFLOW;
                        end
                        else
                        begin
                            push = 1'b1;
                        end
                    end
                end
                ibfq_pkg::OP_QUERY:
                begin
                    res_bit = idx_ok && bm_rdata_reg;
                end
                ibfq_pkg::OP_TAKE:
                begin
                    if (fifo_empty)
                    begin
                        res_status = ibfq_pkg::ST_EMPTY;
                    end
                    else
                    begin
                        pop = 1'b1;
                    end
                end
                default:
                begin
                    res_status = ibfq_pkg::ST_OK;
                end
            endcase
        end
    end

    // counters and pointers
    always_comb
    begin
        if (cmd.sweep_clr)
        begin
            sweep_next = '0;
        end
        else if (cmd.sweep_step)
        begin
            sweep_next = sweep_last ? '0 : sweep_reg + 1'b1;
        end
        else
        begin
            sweep_next = sweep_reg;
        end

        if (cmd.count_clr)
        begin
            used_next = '0;
        end
        else if (used_inc)
        begin
            used_next = used_reg + 1'b1;
        end
        else if (used_dec)
        begin
            used_next = used_reg - 1'b1;
        end
        else
        begin
            used_next = used_reg;
        end

        tail_next = tail_reg;
        head_next = head_reg;
        fill_next = fill_reg;
        if (push)
        begin
            tail_next = (tail_reg == AW'(ENTRIES - 1)) ? '0 : tail_reg + 1'b1;
            fill_next = fill_reg + 1'b1;
        end
        else if (pop)
        begin
            head_next = (head_reg == AW'(ENTRIES - 1)) ? '0 : head_reg + 1'b1;
            fill_next = fill_reg - 1'b1;
        end

        ovf_next = cmd.accept ? 1'b0 : (ovf_reg || ovf_set);
    end

    // result register
    assign used_wide = XW'(used_next);
    assign fidx_wide = XW'(ff_rdata_reg);
    assign res_load  = cmd.exec || cmd.finish;

    always_comb
    begin
        out_valid_next  = out_valid_reg && !out_ready;
        out_bit_next    = out_bit_reg;
        out_fidx_next   = out_fidx_reg;
        out_used_next   = out_used_reg;
        out_status_next = out_status_reg;
        if (res_load)
        begin
            out_valid_next  = 1'b1;
            out_bit_next    = res_bit;
            out_fidx_next   = pop ? fidx_wide[ibfq_pkg::INDEX_W-1:0] : '0;
            out_used_next   = used_wide[ibfq_pkg::COUNT_W-1:0];
            out_status_next = cmd.finish
                              ? (ovf_reg ? ibfq_pkg::ST_OVERFLOW : ibfq_pkg::ST_OK)
                              : res_status;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sweep_reg     <= '0;
            used_reg      <= '0;
            head_reg      <= '0;
            tail_reg      <= '0;
            fill_reg      <= '0;
            ovf_reg       <= 1'b0;
            scan_pend_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            sweep_reg     <= sweep_next;
            used_reg      <= used_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            fill_reg      <= fill_next;
            ovf_reg       <= ovf_next;
            scan_pend_reg <= cmd.scan_issue;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            op_reg  <= in_opcode;
            idx_reg <= in_index;
        end
        scan_idx_reg   <= sweep_reg;
        out_bit_reg    <= out_bit_next;
        out_fidx_reg   <= out_fidx_next;
        out_used_reg   <= out_used_next;
        out_status_reg <= out_status_next;
    end

    // in-use bitmap
    always_ff @(posedge clk)
    begin
        if (bm_we)
        begin
            bm_mem[bm_wa] <= bm_wd;
        end
        bm_rdata_reg <= bm_mem[rd_addr];
    end

    // free index queue
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            ff_mem[tail_reg] <= push_data;
        end
        ff_rdata_reg <= ff_mem[head_reg];
    end

    assign out_valid        = out_valid_reg;
    assign out_entry_in_use = out_bit_reg;
    assign out_free_index   = out_fidx_reg;
    assign out_used_count   = out_used_reg;
    assign out_status       = out_status_reg;

    `AST_ALWAYS(a_used_range, used_reg <= CW'(ENTRIES), "used count above table size")
    `AST_IMP(a_push_room, push, !fifo_full, "push onto full free queue")
    `AST_IMP(a_pop_data, pop, !fifo_empty, "pop from empty free queue")
    `AST_IMP(a_no_overwrite, res_load, sts.out_free, "result overwrites pending result")
    `AST_NEXT(a_scan_pend, cmd.scan_issue, scan_pend_reg, "scan read lost")

endmodule

// ----- hw/rtl/index_allocator_bitmap_free_queue_core.sv -----
`timescale 1ns / 1ps

// index allocator: in-use bitmap, used-entry count and a queue of free indices
// s_* carries one request (opcode, entry index), m_* returns exactly one result
// per request, in order
// mark, release, query and take: one bitmap/queue read, then an update in S_EXEC;
// the result is registered when S_EXEC finds the output register free, and
// s_tready stays low until then, so the next request waits for that result
// rebuild walks all ENTRIES bitmap rows through the single read port, one per
// cycle; S_SCAN_END pushes the last entry if free, then S_FINISH loads the result
// reset table rewrites the bitmap to zero one row a cycle, then S_FINISH loads
// the result
// after rst_n the bitmap is cleared in a pass over all ENTRIES rows with s_tready low
// the free queue memory is not cleared; only its pointers and fill are reset
// a result waits in the output register while m_tready is low; the next request
// is still accepted, but its result is held back until the register drains

module index_allocator_bitmap_free_queue_core
#(
    parameter int ENTRIES = ibfq_pkg::ENTRIES_DEFAULT
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // opcode[2:0], entry_index[12:3], zero pad
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // entry_in_use[0], free_index[10:1],
                                   // used_count[21:11], status[24:22], zero pad
);

    ibfq_pkg::cmd_t cmd;
    ibfq_pkg::sts_t sts;

    logic [ibfq_pkg::OP_W-1:0]     in_opcode;
    logic [ibfq_pkg::INDEX_W-1:0]  in_index;
    logic                          out_entry_in_use;
    logic [ibfq_pkg::INDEX_W-1:0]  out_free_index;
    logic [ibfq_pkg::COUNT_W-1:0]  out_used_count;
    logic [ibfq_pkg::STATUS_W-1:0] out_status;

    // request unpack
    assign in_opcode = s_tdata[2:0];
    assign in_index  = s_tdata[12:3];

    // sequencer: owns the request handshake and steps the sweeps
    ibfq_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_opcode (in_opcode),
        .in_ready  (s_tready),
        .sts       (sts),
        .cmd       (cmd)
    );

    // bitmap, free queue, counters and result register
    ibfq_datapath #(
        .ENTRIES (ENTRIES)
    ) u_datapath
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_opcode        (in_opcode),
        .in_index         (in_index),
        .cmd              (cmd),
        .sts              (sts),
        .out_ready        (m_tready),
        .out_valid        (m_tvalid),
        .out_entry_in_use (out_entry_in_use),
        .out_free_index   (out_free_index),
        .out_used_count   (out_used_count),
        .out_status       (out_status)
    );

    // result pack
    assign m_tdata = {7'd0, out_status, out_used_count, out_free_index, out_entry_in_use};

endmodule
